// File: rtl/dnle_pkg.sv
// Package for the DNS name label encoder.
// Holds the command type passed from the front classifier to the back end.
// No dependencies.
package dnle_pkg;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_DROP,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  localparam logic [7:0] DOT_CODE   = 8'h2E;
  localparam logic [7:0] TERMINATOR = 8'h00;

endpackage

// File: rtl/dnle_if.sv
// Channel interfaces of the DNS name label encoder.
// Input channel carries characters, output channel carries encoded bytes.
// No dependencies.
interface dnle_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_name;

  modport source (output valid, output char_code, output end_of_name, input ready);
  modport sink   (input valid, input char_code, input end_of_name, output ready);
endinterface

interface dnle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       name_done;
  logic       overflow;

  modport source (output valid, output out_byte, output last_of_run,
                  output name_done, output overflow, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input name_done, input overflow, output ready);
endinterface

// File: rtl/dns_name_label_encoder.sv
// DNS name label encoder: dotted host name in, wire-format labels out.
// A dot or end of name passes through the command queue and S_FETCH, and its
// length byte is loaded into the output register in S_LEN. A flush sends the
// length byte, then the stored characters; an end of name adds the terminator
// (after a final dot, empty length bytes first) via the single output register.
// Reset clears counters, flags and queue; label store contents are undefined.
module dns_name_label_encoder
  import dnle_pkg::*;
#(
  parameter int LABEL_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  dnle_char_if.sink   chars,
  dnle_byte_if.source labels
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  dnle_front #(.LABEL_MAX(LABEL_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dnle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  dnle_back #(.LABEL_MAX(LABEL_MAX)) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .labels  (labels)
  );

endmodule

// File: rtl/dnle_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dnle_queue.sv
// Short command queue between front and back of the label encoder.
// Depends on dnle_pkg.
module dnle_queue
  import dnle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/dnle_front.sv
// Front of the label encoder: accepts characters and classifies each item
// as store, drop or flush. Depends on dnle_pkg and dnle_if.
module dnle_front
  import dnle_pkg::*;
#(
  parameter int LABEL_MAX = 32
) (
  input  logic         clk,
  input  logic         rst,
  dnle_char_if.sink    chars,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  localparam int CW = $clog2(LABEL_MAX + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          is_dot;

  assign chars.ready = !q_full;
  assign push        = chars.valid && !q_full;
  assign is_dot      = (chars.char_code == DOT_CODE);

  always_comb begin
    push_cmd.ch   = chars.char_code;
    push_cmd.last = chars.end_of_name;
    count_next    = count;
    if (is_dot) begin
      push_cmd.op = OP_FLUSH;
      count_next  = '0;
    end else if (count < CW'(LABEL_MAX)) begin
      push_cmd.op = OP_STORE;
      count_next  = count + 1'b1;
    end else begin
      push_cmd.op = OP_DROP;
    end
    if (chars.end_of_name) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

// File: rtl/dnle_back.sv
// Back of the label encoder: stores label characters and replays each label
// after its length byte. Depends on dnle_pkg, dnle_if and dnle_ram.
module dnle_back
  import dnle_pkg::*;
#(
  parameter int LABEL_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        q_empty,
  output logic        pop,
  dnle_byte_if.source labels
);

  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  typedef enum logic [1:0] {
    S_FETCH,
    S_LEN,
    S_DATA,
    S_TERM
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic          ovf, ovf_next;
  logic          term_pend, term_pend_next;
  logic          extra, extra_next;

  logic          ovalid, ovalid_next;
  logic [7:0]    obyte, obyte_next;
  logic          olast, olast_next;
  logic          odone, odone_next;
  logic          oovf, oovf_next;

  logic          can_load;
  logic          we;
  logic [7:0]    rdata;
  logic          at_end;

  dnle_ram #(.WIDTH(8), .DEPTH(LABEL_MAX)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (head.ch),
    .raddr (idx_next),
    .rdata (rdata)
  );

  assign can_load = !ovalid || labels.ready;
  assign at_end   = ((CW'(idx) + CW'(1)) == count);

  assign labels.valid       = ovalid;
  assign labels.out_byte    = obyte;
  assign labels.last_of_run = olast;
  assign labels.name_done   = odone;
  assign labels.overflow    = oovf;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    ovf_next       = ovf;
    term_pend_next = term_pend;
    extra_next     = extra;
    ovalid_next    = ovalid && !labels.ready;
    obyte_next     = obyte;
    olast_next     = olast;
    odone_next     = odone;
    oovf_next      = oovf;
    pop            = 1'b0;
    we             = 1'b0;

    case (state)
      S_FETCH: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.op)
            OP_STORE: begin
              we             = 1'b1;
              count_next     = count + 1'b1;
              term_pend_next = head.last;
              extra_next     = 1'b0;
              if (head.last) state_next = S_LEN;
            end
            OP_DROP: begin
              ovf_next       = 1'b1;
              term_pend_next = head.last;
              extra_next     = 1'b0;
              if (head.last) state_next = S_LEN;
            end
            OP_FLUSH: begin
              term_pend_next = head.last;
              extra_next     = head.last;
              state_next     = S_LEN;
            end
            default: begin
              state_next = S_FETCH;
            end
          endcase
        end
      end

      S_LEN: begin
        idx_next = '0;
        if (can_load) begin
          ovalid_next = 1'b1;
          obyte_next  = 8'(count);
          olast_next  = (count == '0) && !term_pend;
          odone_next  = 1'b0;
          oovf_next   = ovf;
          if (count != '0) begin
            state_next = S_DATA;
          end else if (extra) begin
            extra_next = 1'b0;
          end else if (term_pend) begin
            state_next = S_TERM;
          end else begin
            state_next = S_FETCH;
          end
        end
      end

      S_DATA: begin
        if (can_load) begin
          ovalid_next = 1'b1;
          obyte_next  = rdata;
          olast_next  = at_end && !term_pend;
          odone_next  = 1'b0;
          oovf_next   = ovf;
          if (at_end) begin
            count_next = '0;
            if (extra) begin
              extra_next = 1'b0;
              state_next = S_LEN;
            end else if (term_pend) begin
              state_next = S_TERM;
            end else begin
              state_next = S_FETCH;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      S_TERM: begin
        if (can_load) begin
          ovalid_next    = 1'b1;
          obyte_next     = TERMINATOR;
          olast_next     = 1'b1;
          odone_next     = 1'b1;
          oovf_next      = ovf;
          ovf_next       = 1'b0;
          count_next     = '0;
          term_pend_next = 1'b0;
          state_next     = S_FETCH;
        end
      end

      default: begin
        state_next = S_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    obyte <= obyte_next;
    olast <= olast_next;
    odone <= odone_next;
    oovf  <= oovf_next;
    if (rst) begin
      state     <= S_FETCH;
      count     <= '0;
      ovf       <= 1'b0;
      term_pend <= 1'b0;
      extra     <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      term_pend <= term_pend_next;
      extra     <= extra_next;
      ovalid    <= ovalid_next;
    end
  end

endmodule
